>>> rtl/beiq_pkg.sv
package beiq_pkg;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_POLL     = 2'd1,
    OP_ENC_EDGE = 2'd2,
    OP_POWER    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_LONG     = 2'd1,
    REG_UNMUTE   = 2'd2
  } reg_idx_t;

  localparam int unsigned IN_FIELDS = 2;  // button level bits carried by the input

  localparam logic [7:0]  DEBOUNCE_RST = 8'd3;
  localparam logic [15:0] LONG_RST     = 16'd2000;
  localparam logic [15:0] UNMUTE_RST   = 16'd1000;

  localparam logic [3:0] PAT_CW  = 4'b0110;
  localparam logic [3:0] PAT_CCW = 4'b0011;

  typedef struct packed {
    logic tick;
    logic poll;
  } lane_ctl_t;

  typedef struct packed {
    logic short_press;
    logic long_press;
  } lane_res_t;

  typedef struct packed {
    logic step_up;
    logic step_down;
  } enc_res_t;

endpackage

>>> rtl/beiq_button_lane.sv
module beiq_button_lane (
  input  logic                 clk,
  input  logic                 rst_n,
  input  beiq_pkg::lane_ctl_t  ctl,
  input  logic                 level,
  input  logic [7:0]           debounce_ticks,
  input  logic [15:0]          long_press_ticks,
  output beiq_pkg::lane_res_t  res
);

  logic        stable_r, stable_nxt;
  logic        changing_r, changing_nxt;
  logic        held_r, held_nxt;
  logic        long_done_r, long_done_nxt;
  logic [15:0] hold_r, hold_nxt;
  logic [7:0]  settle_r, settle_nxt;

  always_comb begin
    stable_nxt    = stable_r;
    changing_nxt  = changing_r;
    held_nxt      = held_r;
    long_done_nxt = long_done_r;
    hold_nxt      = hold_r;
    settle_nxt    = settle_r;
    res           = '0;
    if (ctl.tick) begin
      if (settle_r != 8'hFF) settle_nxt = settle_r + 8'd1;
      if (hold_r != 16'hFFFF) hold_nxt = hold_r + 16'd1;
    end else if (ctl.poll) begin
      if (level != stable_r && !changing_r) begin
        changing_nxt = 1'b1;
        settle_nxt   = '0;
      end
      if (changing_nxt && settle_nxt >= debounce_ticks) begin
        // take the level seen now, even if it bounced back
        stable_nxt   = level;
        changing_nxt = 1'b0;
        if (!level) begin
          hold_nxt      = '0;
          held_nxt      = 1'b1;
          long_done_nxt = 1'b0;
        end else begin
          held_nxt        = 1'b0;
          res.short_press = (hold_r <= long_press_ticks);
        end
      end
      if (held_nxt && !long_done_nxt && hold_nxt > long_press_ticks) begin
        long_done_nxt  = 1'b1;
        res.long_press = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r    <= 1'b1;
      changing_r  <= 1'b0;
      held_r      <= 1'b0;
      long_done_r <= 1'b0;
      hold_r      <= '0;
      settle_r    <= '0;
    end else begin
      stable_r    <= stable_nxt;
      changing_r  <= changing_nxt;
      held_r      <= held_nxt;
      long_done_r <= long_done_nxt;
      hold_r      <= hold_nxt;
      settle_r    <= settle_nxt;
    end
  end

endmodule

>>> rtl/beiq_encoder.sv
module beiq_encoder (
  input  logic                clk,
  input  logic                rst_n,
  input  beiq_pkg::lane_ctl_t ctl,
  input  logic                edge_a,
  input  logic                enc_a,
  input  logic                enc_b,
  input  logic [7:0]          debounce_ticks,
  output beiq_pkg::enc_res_t  res
);

  logic [1:0] sample_r [2];
  logic [1:0] sample_nxt [2];
  logic       slot_r, slot_nxt;
  logic       pending_r, pending_nxt;
  logic [7:0] settle_r, settle_nxt;
  logic [3:0] pat;

  always_comb begin
    sample_nxt  = sample_r;
    slot_nxt    = slot_r;
    pending_nxt = pending_r;
    settle_nxt  = settle_r;
    pat         = '0;
    res         = '0;
    if (ctl.tick) begin
      if (settle_r != 8'hFF) settle_nxt = settle_r + 8'd1;
    end else if (ctl.poll) begin
      if (pending_r && settle_r >= debounce_ticks) begin
        pending_nxt          = 1'b0;
        sample_nxt[slot_r]   = {enc_a, enc_b};
        slot_nxt             = ~slot_r;
        // older sample sits in the slot not written now
        pat                  = {sample_r[~slot_r], enc_a, enc_b};
        res.step_up          = (pat == beiq_pkg::PAT_CW);
        res.step_down        = (pat == beiq_pkg::PAT_CCW);
      end
    end else if (edge_a && !pending_r) begin
      pending_nxt = 1'b1;
      settle_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r[0] <= '0;
      sample_r[1] <= '0;
      slot_r      <= 1'b0;
      pending_r   <= 1'b0;
      settle_r    <= '0;
    end else begin
      sample_r    <= sample_nxt;
      slot_r      <= slot_nxt;
      pending_r   <= pending_nxt;
      settle_r    <= settle_nxt;
    end
  end

endmodule

>>> rtl/button_encoder_input_qualifier_unit.sv
// Input qualifier for a rotary encoder, long-press buttons and power-on mute.
// Input channel (in_*): tuser carries the operation (tick, poll, encoder A
// edge, power edge); tdata carries the button levels and the A/B levels.
// Every transfer in produces exactly one transfer out on out_*, carrying
// step up/down, short and long press bits per button and the mute level.
// Configuration (cfg_*): index 0 debounce ticks, 1 long press ticks,
// 2 unmute delay ticks; cfg_ready is always high, unknown indexes ignored.
// The result sits in a single output register, valid in the cycle after acceptance.
// Throughput: one item per cycle unless the output stalls; each button has
// its own lane and the encoder its own unit, all updated in the accepting
// cycle; lanes within the input field are merged into the output register.
// Stall: while out_tvalid is high and out_tready low, the result holds and
// in_tready drops; an input is taken in the same cycle the result leaves.
// Reset (rst_n low, synchronous): counters and flags clear, buttons read as
// released, output empty, registers return to 3 / 2000 / 1000.
module button_encoder_input_qualifier_unit #(
  parameter int unsigned BUTTON_COUNT = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [1:0] button_levels, [2] encoder_a, [3] encoder_b
  input  logic [1:0]  in_tuser,   // [1:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] step_up, [1] step_down, [3:2] short_press,
                                  // [5:4] long_press, [6] unmuted
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [7:0]  debounce_r;
  logic [15:0] long_r;
  logic [15:0] unmute_dly_r;

  logic        accept;
  logic        edge_a;
  logic        power;
  beiq_pkg::lane_ctl_t ctl;
  beiq_pkg::enc_res_t  enc_res;
  beiq_pkg::lane_res_t lane_res [BUTTON_COUNT];

  logic [15:0] power_cnt_r, power_cnt_nxt;
  logic        unmute_r, unmute_nxt;

  logic        out_valid_r;
  logic [7:0]  out_data_r;
  logic [1:0]  short_bits, long_bits;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= beiq_pkg::DEBOUNCE_RST;
      long_r       <= beiq_pkg::LONG_RST;
      unmute_dly_r <= beiq_pkg::UNMUTE_RST;
    end else if (cfg_valid) begin
      unique case (beiq_pkg::reg_idx_t'(cfg_index))
        beiq_pkg::REG_DEBOUNCE: debounce_r   <= cfg_data[7:0];
        beiq_pkg::REG_LONG:     long_r       <= cfg_data;
        beiq_pkg::REG_UNMUTE:   unmute_dly_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    ctl    = '0;
    edge_a = 1'b0;
    power  = 1'b0;
    if (accept) begin
      unique case (beiq_pkg::op_t'(in_tuser))
        beiq_pkg::OP_TICK:     ctl.tick = 1'b1;
        beiq_pkg::OP_POLL:     ctl.poll = 1'b1;
        beiq_pkg::OP_ENC_EDGE: edge_a   = 1'b1;
        beiq_pkg::OP_POWER:    power    = 1'b1;
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_lane
    logic lvl;
    // buttons past the input field read as pushed
    if (i < beiq_pkg::IN_FIELDS) begin : g_pin
      assign lvl = in_tdata[i];
    end else begin : g_nopin
      assign lvl = 1'b0;
    end
    beiq_button_lane u_lane (
      .clk              (clk),
      .rst_n            (rst_n),
      .ctl              (ctl),
      .level            (lvl),
      .debounce_ticks   (debounce_r),
      .long_press_ticks (long_r),
      .res              (lane_res[i])
    );
  end

  beiq_encoder u_enc (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .edge_a         (edge_a),
    .enc_a          (in_tdata[2]),
    .enc_b          (in_tdata[3]),
    .debounce_ticks (debounce_r),
    .res            (enc_res)
  );

  always_comb begin
    power_cnt_nxt = power_cnt_r;
    unmute_nxt    = unmute_r;
    if (ctl.tick) begin
      if (power_cnt_r != 16'hFFFF) power_cnt_nxt = power_cnt_r + 16'd1;
    end else if (ctl.poll) begin
      if (power_cnt_r >= unmute_dly_r) unmute_nxt = 1'b1;
    end else if (power) begin
      power_cnt_nxt = '0;
      unmute_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_cnt_r <= '0;
      unmute_r    <= 1'b0;
    end else begin
      power_cnt_r <= power_cnt_nxt;
      unmute_r    <= unmute_nxt;
    end
  end

  // merge lanes; bits beyond the field width are dropped
  for (genvar j = 0; j < beiq_pkg::IN_FIELDS; j++) begin : g_merge
    if (j < BUTTON_COUNT) begin : g_used
      assign short_bits[j] = lane_res[j].short_press;
      assign long_bits[j]  = lane_res[j].long_press;
    end else begin : g_unused
      assign short_bits[j] = 1'b0;
      assign long_bits[j]  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= {1'b0, unmute_nxt, long_bits, short_bits,
                     enc_res.step_down, enc_res.step_up};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> rtl/beiq_checker.sv
module beiq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one result per accepted item: a new result follows an input transfer
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted item gave no result");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !(in_tvalid && in_tready) && (!out_tvalid || out_tready) |=> !out_tvalid)
    else $error("result without input transfer");

  a_step_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("step up and down together");

  a_press_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[3:2] & out_tdata[5:4]) == 2'b00)
    else $error("short and long press on one button together");

endmodule

bind button_encoder_input_qualifier_unit beiq_checker u_beiq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
